[sv/mtrs_pkg.sv]
`timescale 1ns / 1ps
// Package for the transition-count table with weighted successor draw.
// Holds sizes, status and operation codes, and the payload and table entry types.
// No dependencies.
package mtrs_pkg;

   localparam int TableEntries = 16;
   localparam int IdBits       = 16;
   localparam int RandBits     = 16;
   localparam int CountBits    = 24;

   // Widths of the port fields.
   localparam int IdFieldBits   = 16;
   localparam int RandFieldBits = 16;
   localparam int StatusBits    = 2;

   localparam int IdxBits  = $clog2(TableEntries);
   localparam int FillBits = $clog2(TableEntries + 1);
   localparam int SumBits  = CountBits + IdxBits;
   localparam int ProdBits = SumBits + RandBits;

   localparam logic [CountBits-1:0] CountMax = '1;

   localparam logic FuncRecord = 1'b0;
   localparam logic FuncDraw   = 1'b1;

   localparam logic [StatusBits-1:0] StatusOk    = 2'd0;
   localparam logic [StatusBits-1:0] StatusEmpty = 2'd1;
   localparam logic [StatusBits-1:0] StatusFull  = 2'd2;
   localparam logic [StatusBits-1:0] StatusSat   = 2'd3;

   typedef struct packed {
      logic                     func;
      logic [IdFieldBits-1:0]   target_id;
      logic [RandFieldBits-1:0] random_fraction;
   } req_type;

   typedef struct packed {
      logic [IdFieldBits-1:0] chosen_id;
      logic [StatusBits-1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [IdBits-1:0]    key;
      logic [CountBits-1:0] count;
   } entry_type;

endpackage

[sv/markov_transition_roulette_select.sv]
`timescale 1ns / 1ps
// A draw walks the held entries in order until the weighted pick; a record goes through
// scan, shift of the sorted table and place (scan alone for an id already held or a full
// table). Either loads its result once the output register is free.
// Throughput: one item at a time; the next transfer is taken the cycle after the result
// is loaded. One entry per cycle through the table RAM during scan, shift and draw.
// Reset: synchronous; the table is empty (fill count zero), no result pending.
// Table RAM contents need no reset: only entries below the fill count are read.
// Transition-count table kept sorted by id in a RAM, with a weighted successor draw.
// Depends on mtrs_pkg.
module markov_transition_roulette_select (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mtrs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mtrs_pkg::rsp_type rsp_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_PLACE = 3'd3;
   localparam logic [2:0] S_DRAW  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;

   logic [mtrs_pkg::IdBits-1:0]     id_ff, id_in;
   logic [mtrs_pkg::ProdBits-1:0]   product_ff, product_in;
   logic [mtrs_pkg::FillBits-1:0]   fill_ff, fill_in;
   logic [mtrs_pkg::SumBits-1:0]    sum_ff, sum_in;
   logic [mtrs_pkg::FillBits-1:0]   rd_idx_ff, rd_idx_in;
   logic                            chk_valid_ff, chk_valid_in;
   logic [mtrs_pkg::IdxBits-1:0]    chk_idx_ff, chk_idx_in;
   logic [mtrs_pkg::IdxBits-1:0]    pos_ff, pos_in;
   logic [mtrs_pkg::FillBits-1:0]   src_ff, src_in;
   logic [mtrs_pkg::SumBits-1:0]    prefix_ff, prefix_in;
   logic [mtrs_pkg::IdBits-1:0]     chosen_ff, chosen_in;
   logic [mtrs_pkg::StatusBits-1:0] status_ff, status_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   mtrs_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   // Table RAM, kept sorted by key over entries [0, fill).
   mtrs_pkg::entry_type mem [mtrs_pkg::TableEntries];
   mtrs_pkg::entry_type rd_data_ff;
   mtrs_pkg::entry_type wr_data;
   logic                         rd_en, wr_en;
   logic [mtrs_pkg::IdxBits-1:0] rd_addr, wr_addr;

   logic [mtrs_pkg::RandBits-1:0] rand_u;
   logic [mtrs_pkg::SumBits-1:0]  prefix_next;
   logic                          draw_hit;
   logic                          table_full;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rand_u      = mtrs_pkg::RandBits'(req_data.random_fraction);
   assign prefix_next = prefix_ff + mtrs_pkg::SumBits'(rd_data_ff.count);
   assign draw_hit    = chk_valid_ff &&
                        ({prefix_next, {mtrs_pkg::RandBits{1'b0}}} >= product_ff);
   assign table_full  = (fill_ff == mtrs_pkg::FillBits'(mtrs_pkg::TableEntries));

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      state_in     = state_ff;
      id_in        = id_ff;
      product_in   = product_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      rd_idx_in    = rd_idx_ff;
      chk_valid_in = chk_valid_ff;
      chk_idx_in   = chk_idx_ff;
      pos_in       = pos_ff;
      src_in       = src_ff;
      prefix_in    = prefix_ff;
      chosen_in    = chosen_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = rd_idx_ff[mtrs_pkg::IdxBits-1:0];
      wr_en        = 1'b0;
      wr_addr      = chk_idx_ff;
      wr_data      = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               id_in        = mtrs_pkg::IdBits'(req_data.target_id);
               product_in   = mtrs_pkg::ProdBits'(rand_u) * mtrs_pkg::ProdBits'(sum_ff);
               rd_idx_in    = '0;
               chk_valid_in = 1'b0;
               prefix_in    = '0;
               chosen_in    = '0;
               status_in    = mtrs_pkg::StatusOk;
               if (req_data.func == mtrs_pkg::FuncDraw) begin
                  if (fill_ff == '0) begin
                     status_in = mtrs_pkg::StatusEmpty;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_DRAW;
                  end
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (chk_valid_ff && rd_data_ff.key == id_ff) begin
               // Existing id: bump its count unless it is pegged.
               if (rd_data_ff.count == mtrs_pkg::CountMax) begin
                  status_in = mtrs_pkg::StatusSat;
               end else begin
                  wr_en         = 1'b1;
                  wr_addr       = chk_idx_ff;
                  wr_data.key   = rd_data_ff.key;
                  wr_data.count = rd_data_ff.count + 1'b1;
                  sum_in        = sum_ff + 1'b1;
               end
               state_in = S_DONE;
            end else if ((chk_valid_ff && rd_data_ff.key > id_ff) ||
                         (!chk_valid_ff && rd_idx_ff == fill_ff)) begin
               // Insertion point found: first larger key, or end of table.
               if (table_full) begin
                  status_in = mtrs_pkg::StatusFull;
                  state_in  = S_DONE;
               end else begin
                  pos_in       = chk_valid_ff ? chk_idx_ff
                                              : fill_ff[mtrs_pkg::IdxBits-1:0];
                  src_in       = fill_ff;
                  chk_valid_in = 1'b0;
                  state_in     = S_SHIFT;
               end
            end else if (rd_idx_ff < fill_ff) begin
               rd_en        = 1'b1;
               rd_addr      = rd_idx_ff[mtrs_pkg::IdxBits-1:0];
               chk_idx_in   = rd_idx_ff[mtrs_pkg::IdxBits-1:0];
               chk_valid_in = 1'b1;
               rd_idx_in    = rd_idx_ff + 1'b1;
            end else begin
               chk_valid_in = 1'b0;
            end
         end

         S_SHIFT: begin
            // Move entries [pos, fill) up by one, top first; read one, write the last.
            if (chk_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = chk_idx_ff + 1'b1;
               wr_data = rd_data_ff;
            end
            if (src_ff > mtrs_pkg::FillBits'(pos_ff)) begin
               rd_en        = 1'b1;
               rd_addr      = mtrs_pkg::IdxBits'(src_ff - 1'b1);
               chk_idx_in   = mtrs_pkg::IdxBits'(src_ff - 1'b1);
               chk_valid_in = 1'b1;
               src_in       = src_ff - 1'b1;
            end else begin
               chk_valid_in = 1'b0;
               state_in     = S_PLACE;
            end
         end

         S_PLACE: begin
            wr_en         = 1'b1;
            wr_addr       = pos_ff;
            wr_data.key   = id_ff;
            wr_data.count = mtrs_pkg::CountBits'(1);
            fill_in       = fill_ff + 1'b1;
            sum_in        = sum_ff + 1'b1;
            state_in      = S_DONE;
         end

         S_DRAW: begin
            if (draw_hit) begin
               chosen_in = rd_data_ff.key;
               state_in  = S_DONE;
            end else begin
               if (chk_valid_ff) begin
                  prefix_in = prefix_next;
               end
               if (rd_idx_ff < fill_ff) begin
                  rd_en        = 1'b1;
                  rd_addr      = rd_idx_ff[mtrs_pkg::IdxBits-1:0];
                  chk_valid_in = 1'b1;
                  rd_idx_in    = rd_idx_ff + 1'b1;
               end else if (!chk_valid_ff) begin
                  state_in = S_DONE;
               end else begin
                  chk_valid_in = 1'b0;
               end
            end
         end

         S_DONE: begin
            // Hold until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.chosen_id = mtrs_pkg::IdFieldBits'(chosen_ff);
               rsp_data_in.status    = status_ff;
               rsp_valid_in          = 1'b1;
               state_in              = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         sum_ff       <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      product_ff  <= product_in;
      rd_idx_ff   <= rd_idx_in;
      chk_idx_ff  <= chk_idx_in;
      pos_ff      <= pos_in;
      src_ff      <= src_in;
      prefix_ff   <= prefix_in;
      chosen_ff   <= chosen_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= mtrs_pkg::FillBits'(mtrs_pkg::TableEntries))
      else $error("fill count beyond table size");

   a_sum_covers_fill: assert property (@(posedge clock) disable iff (reset)
      sum_ff >= mtrs_pkg::SumBits'(fill_ff))
      else $error("total count below number of entries");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(state_ff) == S_DONE)
      else $error("result loaded outside completion state");

   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_SCAN || state_ff == S_SHIFT || state_ff == S_PLACE))
      else $error("table write outside record path");

   a_fill_grows_by_place: assert property (@(posedge clock) disable iff (reset)
      fill_ff != $past(fill_ff) |-> $past(state_ff) == S_PLACE)
      else $error("fill count changed outside insertion");

endmodule
